FILE: design/tcw_pkg.sv
package tcw_pkg;

    localparam int DEF_COLS  = 80;
    localparam int DEF_ROWS  = 25;

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int REQ_W     = 16;
    localparam int IDX_W     = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int WORD_W    = 16;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_DONE
    } t_state;

endpackage

FILE: design/tcw_in_if.sv
interface tcw_in_if;
    logic                              valid;
    logic                              ready;
    logic [tcw_pkg::CMD_W-1:0]         cmd;
    logic [tcw_pkg::CHAR_W-1:0]        char_code;
    logic [tcw_pkg::ATTR_W-1:0]        color;
    logic signed [tcw_pkg::REQ_W-1:0]  row_request;
    logic signed [tcw_pkg::REQ_W-1:0]  col_request;
    logic [tcw_pkg::IDX_W-1:0]         cell_index;

    modport source (
        output valid, cmd, char_code, color, row_request, col_request, cell_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, char_code, color, row_request, col_request, cell_index,
        output ready
    );
endinterface

FILE: design/tcw_out_if.sv
interface tcw_out_if;
    logic                             valid;
    logic                             ready;
    logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row_out;
    logic [tcw_pkg::COL_OUT_W-1:0]    cursor_col_out;
    logic [tcw_pkg::WORD_W-1:0]       cell_word;

    modport source (
        output valid, cursor_row_out, cursor_col_out, cell_word,
        input  ready
    );
    modport sink (
        input  valid, cursor_row_out, cursor_col_out, cell_word,
        output ready
    );
endinterface

FILE: design/tcw_ram.sv
module tcw_ram #(
    parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [tcw_pkg::WORD_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [tcw_pkg::WORD_W-1:0]  o_rdata
);

    logic [tcw_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tcw_ctrl.sv
module tcw_ctrl #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS,
    localparam int CELLS  = ROWS * COLS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_blank_attr,
    tcw_in_if.sink                      i_in,
    tcw_out_if.source                   o_out,
    output logic                        o_we,
    output logic [ADDR_W-1:0]           o_waddr,
    output logic [tcw_pkg::WORD_W-1:0]  o_wdata,
    output logic                        o_re,
    output logic [ADDR_W-1:0]           o_raddr,
    input  logic [tcw_pkg::WORD_W-1:0]  i_rdata
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int CMP_W  = (ADDR_W > tcw_pkg::IDX_W) ? ADDR_W : tcw_pkg::IDX_W;
    localparam logic signed [tcw_pkg::REQ_W-1:0] ROW_MAX_S = tcw_pkg::REQ_W'(ROWS - 1);
    localparam logic signed [tcw_pkg::REQ_W-1:0] COL_MAX_S = tcw_pkg::REQ_W'(COLS - 1);
    localparam logic signed [tcw_pkg::REQ_W-1:0] REQ_ZERO  = '0;

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_cmd   cmd;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  cnt_dec, cnt_fwd;
    logic              r_rd_sel, n_rd_sel;
    logic              r_out_valid, n_out_valid;
    logic [tcw_pkg::ROW_OUT_W-1:0] r_out_row;
    logic [tcw_pkg::COL_OUT_W-1:0] r_out_col;
    logic [tcw_pkg::WORD_W-1:0]    r_out_word;

    logic accept, out_free, load;
    logic row_last, col_last, is_nl, is_cr, is_bs, scroll_req;
    logic sweep_last, scroll_last;
    logic [tcw_pkg::WORD_W-1:0] blank_word;

    assign cmd        = tcw_pkg::t_cmd'(i_in.cmd);
    assign i_in.ready = (r_state == tcw_pkg::ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign row_last   = (r_row == ROW_W'(ROWS - 1));
    assign col_last   = (r_col == COL_W'(COLS - 1));
    assign is_nl      = (i_in.char_code == tcw_pkg::CH_NEWLINE);
    assign is_cr      = (i_in.char_code == tcw_pkg::CH_RETURN);
    assign is_bs      = (i_in.char_code == tcw_pkg::CH_BACKSPACE);
    assign scroll_req = (cmd == tcw_pkg::CMD_PUT) && row_last
                        && (is_nl || (!is_cr && !is_bs && col_last));

    assign sweep_last  = (r_cnt == CNT_W'(CELLS - 1));
    assign scroll_last = (r_cnt == CNT_W'(CELLS));
    assign cnt_dec     = r_cnt - CNT_W'(1);
    assign cnt_fwd     = r_cnt + CNT_W'(COLS);
    assign blank_word  = {i_blank_attr, tcw_pkg::CH_SPACE};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_INIT: begin
                if (sweep_last) n_state = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (cmd == tcw_pkg::CMD_CLEAR) n_state = tcw_pkg::ST_CLEAR;
                    else if (scroll_req)           n_state = tcw_pkg::ST_SCROLL;
                    else                           n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_CLEAR: begin
                if (sweep_last) n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL: begin
                if (scroll_last) n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (out_free) n_state = tcw_pkg::ST_IDLE;
            end
            default: n_state = tcw_pkg::ST_INIT;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_rd_sel = r_rd_sel;
        o_we     = 1'b0;
        o_waddr  = r_addr;
        o_wdata  = blank_word;
        o_re     = 1'b0;
        o_raddr  = ADDR_W'(i_in.cell_index);
        load     = 1'b0;
        case (r_state)
            tcw_pkg::ST_INIT: begin
                o_we    = 1'b1;
                o_waddr = r_cnt[ADDR_W-1:0];
                o_wdata = {tcw_pkg::BLANK_ATTR_RESET, tcw_pkg::CH_SPACE};
                n_cnt   = sweep_last ? '0 : r_cnt + CNT_W'(1);
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_rd_sel = 1'b0;
                    case (cmd)
                        tcw_pkg::CMD_PUT: begin
                            if (is_nl) begin
                                n_col = '0;
                                if (!row_last) n_row = r_row + ROW_W'(1);
                            end else if (is_cr) begin
                                n_col = '0;
                            end else if (is_bs) begin
                                o_we    = 1'b1;
                                o_waddr = (r_addr == '0) ? '0 : r_addr - ADDR_W'(1);
                                if (r_col != '0) begin
                                    n_col = r_col - COL_W'(1);
                                end else if (r_row != '0) begin
                                    n_row = r_row - ROW_W'(1);
                                    n_col = COL_W'(COLS - 1);
                                end
                            end else begin
                                o_we    = 1'b1;
                                o_wdata = {i_in.color, i_in.char_code};
                                if (col_last) begin
                                    n_col = '0;
                                    if (!row_last) n_row = r_row + ROW_W'(1);
                                end else begin
                                    n_col = r_col + COL_W'(1);
                                end
                            end
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            n_row = '0;
                            n_col = '0;
                        end
                        tcw_pkg::CMD_SET: begin
                            if (i_in.row_request < REQ_ZERO)       n_row = '0;
                            else if (i_in.row_request > ROW_MAX_S) n_row = ROW_W'(ROWS - 1);
                            else                                   n_row = i_in.row_request[ROW_W-1:0];
                            if (i_in.col_request < REQ_ZERO)       n_col = '0;
                            else if (i_in.col_request > COL_MAX_S) n_col = COL_W'(COLS - 1);
                            else                                   n_col = i_in.col_request[COL_W-1:0];
                        end
                        tcw_pkg::CMD_READ: begin
                            o_re     = 1'b1;
                            n_rd_sel = (CMP_W'(i_in.cell_index) < CMP_W'(CELLS));
                        end
                        default: ;
                    endcase
                end
            end
            tcw_pkg::ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt[ADDR_W-1:0];
                n_cnt   = sweep_last ? '0 : r_cnt + CNT_W'(1);
            end
            tcw_pkg::ST_SCROLL: begin
                // read one row ahead, write back the previous read in the next cycle
                o_we    = (r_cnt != '0);
                o_waddr = cnt_dec[ADDR_W-1:0];
                o_wdata = (r_cnt <= CNT_W'(CELLS - COLS)) ? i_rdata : blank_word;
                o_re    = (r_cnt < CNT_W'(CELLS - COLS));
                o_raddr = cnt_fwd[ADDR_W-1:0];
                n_cnt   = scroll_last ? '0 : r_cnt + CNT_W'(1);
            end
            tcw_pkg::ST_DONE: begin
                load = out_free;
            end
            default: ;
        endcase
    end

    assign n_out_valid = load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= ADDR_W'(r_row * COLS + r_col);
        r_rd_sel <= n_rd_sel;
        if (load) begin
            r_out_row  <= tcw_pkg::ROW_OUT_W'(r_row);
            r_out_col  <= tcw_pkg::COL_OUT_W'(r_col);
            r_out_word <= r_rd_sel ? i_rdata : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cursor_row_out = r_out_row;
    assign o_out.cursor_col_out = r_out_col;
    assign o_out.cell_word      = r_out_word;

endmodule

FILE: design/text_console_writer_top.sv
// Text console writer: keeps a ROWS x COLS screen of 16-bit cells (attribute in the high
// byte, character in the low byte) in a single-port-write, registered-read memory, plus a
// cursor, and answers every command transaction with one result transaction carrying the
// cursor and, for a cell read, the cell word. After reset the block walks the memory once
// to blank it, one cell per cycle, before input ready first rises. Put character, set
// cursor and read cell go through accept, then result load; clear screen and a put
// character that scrolls are paced by the one-cell-per-cycle sweep of the memory write
// port. A finished result sits in an output register, so a new command is taken while
// the previous result still waits. blank_attribute is written through i_cfg_we /
// i_cfg_data and affects cells blanked by later commands.
module text_console_writer_top #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcw_in_if.sink                      i_in,
    tcw_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_data
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [tcw_pkg::ATTR_W-1:0] r_blank_attr;
    logic                       we, re;
    logic [ADDR_W-1:0]          waddr, raddr;
    logic [tcw_pkg::WORD_W-1:0] wdata, rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= tcw_pkg::BLANK_ATTR_RESET;
        end else if (i_cfg_we) begin
            r_blank_attr <= i_cfg_data;
        end
    end

    tcw_ctrl #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blank_attr (r_blank_attr),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    tcw_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // reset empties the result slot and starts the blanking sweep
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !i_in.ready)
        else $error("result pending or input ready right after reset");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input ready in the cycle after an accepted transaction");

    // a set cursor to home shows up as a home result once the slot frees
    a_set_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == tcw_pkg::CMD_SET
         && i_in.row_request == '0 && i_in.col_request == '0)
        ##1 (!o_out.valid || o_out.ready)
        |=> o_out.valid && o_out.cursor_row_out == '0 && o_out.cursor_col_out == '0
            && o_out.cell_word == '0)
        else $error("set cursor result does not report home");

    // reported column never leaves the screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.cursor_col_out) < COLS))
        else $error("reported cursor column beyond last column");

endmodule

FILE: verif/text_console_writer_top_tb.sv
`timescale 1ns / 100ps

module text_console_writer_top_tb;

    localparam int COLS        = tcw_pkg::DEF_COLS;
    localparam int ROWS        = tcw_pkg::DEF_ROWS;
    localparam int CELLS       = ROWS * COLS;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        tcw_pkg::t_cmd                cmd;
        logic [tcw_pkg::CHAR_W-1:0]   char_code;
        logic [tcw_pkg::ATTR_W-1:0]   color;
        logic [tcw_pkg::REQ_W-1:0]    row_request;
        logic [tcw_pkg::REQ_W-1:0]    col_request;
        logic [tcw_pkg::IDX_W-1:0]    cell_index;
    } t_console_cmd;

    typedef struct packed {
        logic [tcw_pkg::ROW_OUT_W-1:0] res_row;
        logic [tcw_pkg::COL_OUT_W-1:0] res_col;
        logic [tcw_pkg::WORD_W-1:0]    cell_word;
    } t_console_result;

    class t_console_scoreboard;
        logic [tcw_pkg::WORD_W-1:0] screen [CELLS];
        int                         cur_row;
        int                         cur_col;
        logic [tcw_pkg::ATTR_W-1:0] blank_attr;
        t_console_result            pending_results[$];
        int unsigned                error_count;
        int unsigned                checked_count;
        int unsigned                command_count;
        int unsigned                scroll_count;
        int unsigned                clear_count;

        function new();
            blank_attr = tcw_pkg::BLANK_ATTR_RESET;
            cur_row    = 0;
            cur_col    = 0;
            blank_all();
        endfunction

        function logic [tcw_pkg::WORD_W-1:0] blank_word();
            return {blank_attr, tcw_pkg::CH_SPACE};
        endfunction

        function void blank_all();
            for (int k = 0; k < CELLS; k++) screen[k] = blank_word();
        endfunction

        // works out the console state and the result for one accepted command
        function void note_command(t_console_cmd c);
            int              r;
            t_console_result res;
            res.cell_word = '0;
            command_count++;
            case (c.cmd)
                tcw_pkg::CMD_PUT: begin
                    if (c.char_code == tcw_pkg::CH_NEWLINE) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (c.char_code == tcw_pkg::CH_RETURN) begin
                        cur_col = 0;
                    end else if (c.char_code == tcw_pkg::CH_BACKSPACE) begin
                        if (cur_col > 0) begin
                            cur_col--;
                        end else if (cur_row > 0) begin
                            cur_row--;
                            cur_col = COLS - 1;
                        end
                        screen[cur_row * COLS + cur_col] = blank_word();
                    end else begin
                        screen[cur_row * COLS + cur_col] = {c.color, c.char_code};
                        cur_col++;
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    if (cur_row >= ROWS) begin
                        for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
                        for (int k = CELLS - COLS; k < CELLS; k++) screen[k] = blank_word();
                        cur_row = ROWS - 1;
                        scroll_count++;
                    end
                end
                tcw_pkg::CMD_CLEAR: begin
                    blank_all();
                    cur_row = 0;
                    cur_col = 0;
                    clear_count++;
                end
                tcw_pkg::CMD_SET: begin
                    r = $signed(c.row_request);
                    cur_row = (r < 0) ? 0 : (r > ROWS - 1) ? ROWS - 1 : r;
                    r = $signed(c.col_request);
                    cur_col = (r < 0) ? 0 : (r > COLS - 1) ? COLS - 1 : r;
                end
                default: begin
                    if (c.cell_index < CELLS) res.cell_word = screen[c.cell_index];
                end
            endcase
            res.res_row = tcw_pkg::ROW_OUT_W'(cur_row);
            res.res_col = tcw_pkg::COL_OUT_W'(cur_col);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_console_result got);
            t_console_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual row %0d col %0d word %h",
                         $time, got.res_row, got.res_col, got.cell_word);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            checked_count++;
            compare_field("cursor row", 16'(want.res_row), 16'(got.res_row));
            compare_field("cursor col", 16'(want.res_col), 16'(got.res_col));
            compare_field("cell word", want.cell_word, got.cell_word);
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [tcw_pkg::ATTR_W-1:0] i_cfg_data;

    tcw_in_if  in_if ();
    tcw_out_if out_if ();

    t_console_scoreboard sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  stall_cycles = 0;

    text_console_writer_top #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check each transaction, then decide the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(t_console_result'({out_if.cursor_row_out, out_if.cursor_col_out,
                                               out_if.cell_word}));
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // random filler in every field, then the fields the command uses
    function automatic t_console_cmd shaped(tcw_pkg::t_cmd op, int arg_a, int arg_b);
        t_console_cmd c;
        c.cmd         = op;
        c.char_code   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        c.color       = tcw_pkg::ATTR_W'($urandom_range(0, 255));
        c.row_request = tcw_pkg::REQ_W'($urandom);
        c.col_request = tcw_pkg::REQ_W'($urandom);
        c.cell_index  = tcw_pkg::IDX_W'($urandom_range(0, 2047));
        case (op)
            tcw_pkg::CMD_PUT: begin
                c.char_code = arg_a[tcw_pkg::CHAR_W-1:0];
                c.color     = arg_b[tcw_pkg::ATTR_W-1:0];
            end
            tcw_pkg::CMD_SET: begin
                c.row_request = arg_a[tcw_pkg::REQ_W-1:0];
                c.col_request = arg_b[tcw_pkg::REQ_W-1:0];
            end
            tcw_pkg::CMD_READ: c.cell_index = arg_a[tcw_pkg::IDX_W-1:0];
            default: ;
        endcase
        return c;
    endfunction

    function automatic int random_coord(int span);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return $urandom_range(0, span - 1);
        if (sel < 70) return ($urandom_range(0, 1) == 0) ? 0 : span - 1;
        return int'($signed(16'($urandom)));
    endfunction

    function automatic t_console_cmd random_command();
        int sel;
        int ch;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            sel = $urandom_range(0, 99);
            if (sel < 10)      ch = int'(tcw_pkg::CH_NEWLINE);
            else if (sel < 16) ch = int'(tcw_pkg::CH_RETURN);
            else if (sel < 28) ch = int'(tcw_pkg::CH_BACKSPACE);
            else               ch = $urandom_range(0, 255);
            return shaped(tcw_pkg::CMD_PUT, ch, $urandom_range(0, 255));
        end
        if (sel < 82)
            return shaped(tcw_pkg::CMD_SET, random_coord(ROWS), random_coord(COLS));
        if (sel < 98)
            return shaped(tcw_pkg::CMD_READ, ($urandom_range(0, 99) < 85) ?
                          $urandom_range(0, CELLS - 1) : $urandom_range(0, 2047), 0);
        return shaped(tcw_pkg::CMD_CLEAR, 0, 0);
    endfunction

    task automatic send_command(t_console_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.cmd         <= c.cmd;
        in_if.char_code   <= c.char_code;
        in_if.color       <= c.color;
        in_if.row_request <= c.row_request;
        in_if.col_request <= c.col_request;
        in_if.cell_index  <= c.cell_index;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic run_random(int count);
        repeat (count) send_command(random_command());
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_blank_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.blank_attr = value;
    endtask

    initial begin
        logic [tcw_pkg::ATTR_W-1:0] mixed_attr;
        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.cmd         = tcw_pkg::CMD_PUT;
        in_if.char_code   = '0;
        in_if.color       = '0;
        in_if.row_request = '0;
        in_if.col_request = '0;
        in_if.cell_index  = '0;
        out_if.ready      = 1'b0;
        send_idle_pct     = 29;
        recv_idle_pct     = 62;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents and out-of-range reads
        send_command(shaped(tcw_pkg::CMD_READ, 0, 0));
        send_command(shaped(tcw_pkg::CMD_READ, CELLS - 1, 0));
        send_command(shaped(tcw_pkg::CMD_READ, CELLS, 0));
        send_command(shaped(tcw_pkg::CMD_READ, 2047, 0));
        // printing, return and backspace at home
        send_command(shaped(tcw_pkg::CMD_PUT, 'h41, 'hFF));
        send_command(shaped(tcw_pkg::CMD_PUT, 'h00, 'h00));
        send_command(shaped(tcw_pkg::CMD_PUT, 'hFF, 'h5A));
        send_command(shaped(tcw_pkg::CMD_PUT, int'(tcw_pkg::CH_RETURN), 'h12));
        send_command(shaped(tcw_pkg::CMD_PUT, int'(tcw_pkg::CH_BACKSPACE), 'h34));
        // wrap at end of row, then backspace at column zero
        send_command(shaped(tcw_pkg::CMD_SET, 0, COLS - 1));
        send_command(shaped(tcw_pkg::CMD_PUT, 'h78, 'h1E));
        send_command(shaped(tcw_pkg::CMD_PUT, int'(tcw_pkg::CH_BACKSPACE), 'h00));
        send_command(shaped(tcw_pkg::CMD_PUT, int'(tcw_pkg::CH_NEWLINE), 'hA5));
        // cursor clamping
        send_command(shaped(tcw_pkg::CMD_SET, -32768, -32768));
        send_command(shaped(tcw_pkg::CMD_SET, 32767, 32767));
        send_command(shaped(tcw_pkg::CMD_SET, -1, COLS + 20));
        // scroll by wrap and by newline
        send_command(shaped(tcw_pkg::CMD_SET, ROWS - 1, COLS - 1));
        send_command(shaped(tcw_pkg::CMD_PUT, 'h5A, 'hC3));
        send_command(shaped(tcw_pkg::CMD_READ, CELLS - COLS - 1, 0));
        send_command(shaped(tcw_pkg::CMD_SET, ROWS - 1, 5));
        send_command(shaped(tcw_pkg::CMD_PUT, int'(tcw_pkg::CH_NEWLINE), 'h00));
        send_command(shaped(tcw_pkg::CMD_READ, CELLS - COLS - 1, 0));
        send_command(shaped(tcw_pkg::CMD_CLEAR, 0, 0));
        send_command(shaped(tcw_pkg::CMD_READ, CELLS - COLS - 1, 0));
        send_command(shaped(tcw_pkg::CMD_READ, 0, 0));
        drain_results();

        set_blank_attribute(8'hFF);
        run_random(470);
        drain_results();

        send_idle_pct = 62;
        recv_idle_pct = 29;
        set_blank_attribute(8'h00);
        run_random(470);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        mixed_attr    = tcw_pkg::ATTR_W'($urandom_range(1, 254));
        set_blank_attribute(mixed_attr);
        run_random(460);
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("run covered %0d commands with %0d results checked, %0d scrolls, %0d clears",
                 sb.command_count, sb.checked_count, sb.scroll_count, sb.clear_count);
        $display("blank attributes 0x07, 0xff, 0x00 and 0x%02h under three idle mixes",
                 mixed_attr);
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.error_count,
                     sb.pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
